// File: rtl/vppm_pkg.sv
// Shared widths, register indexes and effect-mode constants of the plane mixer.
package vppm_pkg;

    localparam int PIX_W  = 16;
    localparam int FLAG_W = 2;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 16;
    localparam int PRI_W  = 8;
    localparam int EFF_W  = 8;
    localparam int PLN_W  = 5;

    typedef logic [PIX_W-1:0] pix_t;

    typedef enum logic [IDX_W-1:0] {
        REG_PRIORITY  = 3'd0,
        REG_EFFECT    = 3'd1,
        REG_PLANE     = 3'd2,
        REG_HALF_MASK = 3'd3,
        REG_INT_BIT   = 3'd4,
        REG_INT_ADD   = 3'd5
    } cfg_index_t;

    localparam logic [EFF_W-1:0] EFF_HALF_MASK   = 8'h5d;
    localparam logic [EFF_W-1:0] EFF_HALF_MODE   = 8'h1d;
    localparam logic [EFF_W-1:0] EFF_FILL_MODE   = 8'h1c;
    localparam logic [EFF_W-1:0] EFF_SPRI_MASK   = 8'h5c;
    localparam logic [EFF_W-1:0] EFF_SPRI_MODE   = 8'h14;
    localparam logic [EFF_W-1:0] EFF_GRAPH_BLEND = 8'h10;

    localparam int PLN_GFX   = 0;
    localparam int PLN_TRANS = 1;
    localparam int PLN_SPRI  = 2;
    localparam int PLN_TEXT  = 3;
    localparam int PLN_BG    = 4;

    localparam int FLG_TEXT = 0;
    localparam int FLG_BG   = 1;

endpackage

// File: rtl/vppm_pix_if.sv
// Input pixel channel: one dot of all four planes plus the text/BG flags.
interface vppm_pix_if;
    logic                          valid;
    logic                          ready;
    logic [vppm_pkg::PIX_W-1:0]    graphics_pixel;
    logic [vppm_pkg::PIX_W-1:0]    sprite_graphics_pixel;
    logic [vppm_pkg::PIX_W-1:0]    plain_graphics_pixel;
    logic [vppm_pkg::PIX_W-1:0]    text_bg_pixel;
    logic [vppm_pkg::FLAG_W-1:0]   text_bg_flags;

    modport source (
        output valid, graphics_pixel, sprite_graphics_pixel, plain_graphics_pixel,
               text_bg_pixel, text_bg_flags,
        input  ready
    );
    modport sink (
        input  valid, graphics_pixel, sprite_graphics_pixel, plain_graphics_pixel,
               text_bg_pixel, text_bg_flags,
        output ready
    );
endinterface

// File: rtl/vppm_scr_if.sv
// Output channel carrying the composited screen pixel.
interface vppm_scr_if;
    logic                          valid;
    logic                          ready;
    logic [vppm_pkg::PIX_W-1:0]    screen_pixel;

    modport source (
        output valid, screen_pixel,
        input  ready
    );
    modport sink (
        input  valid, screen_pixel,
        output ready
    );
endinterface

// File: rtl/vppm_cfg_if.sv
// Register write channel: index and data.
interface vppm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [vppm_pkg::IDX_W-1:0]    index;
    logic [vppm_pkg::CFG_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: rtl/video_plane_priority_mixer.sv
// Top level of the video plane priority mixer.
// Takes one dot per clock and returns one composited screen pixel per dot. A dot is
// registered on entry, composited by a chain of priority muxes and one blend adder, and
// registered again on exit. A new beat is taken every cycle while the output side keeps
// up. Register writes apply to dots composited after them; write them only while no
// dot is in flight.
module video_plane_priority_mixer (
    input  logic        clk,
    input  logic        rst_n,
    vppm_pix_if.sink    pixel,
    vppm_scr_if.source  screen,
    vppm_cfg_if.sink    cfg
);

    logic [vppm_pkg::PRI_W-1:0] priority_reg;
    logic [vppm_pkg::EFF_W-1:0] effect_reg;
    logic [vppm_pkg::PLN_W-1:0] plane_reg;
    vppm_pkg::pix_t             half_mask_reg;
    vppm_pkg::pix_t             int_bit_reg;
    vppm_pkg::pix_t             int_add_reg;

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    vppm_pkg::pix_t              g_reg;
    vppm_pkg::pix_t              s_reg;
    vppm_pkg::pix_t              p_reg;
    vppm_pkg::pix_t              t_reg;
    logic [vppm_pkg::FLAG_W-1:0] f_reg;

    logic                        s2_valid_reg;
    logic                        s2_valid_next;
    vppm_pkg::pix_t              scr_reg;
    vppm_pkg::pix_t              scr_next;

    logic                        advance;
    logic                        take;
    vppm_pkg::pix_t              w_mask;
    vppm_pkg::pix_t              w_sum;
    logic [vppm_pkg::PIX_W:0]    blend_sum;
    vppm_pkg::pix_t              blend;

    function automatic vppm_pkg::pix_t put(input vppm_pkg::pix_t scr, input vppm_pkg::pix_t v,
                                           input logic opaq);
        put = (opaq || v != '0) ? v : scr;
    endfunction

    function automatic vppm_pkg::pix_t tb_line(input vppm_pkg::pix_t scr, input logic opaq,
                                               input logic td, input logic fbit,
                                               input vppm_pkg::pix_t t);
        if (opaq)
            tb_line = t;
        else if ((!td || fbit) && t != '0)
            tb_line = t;
        else
            tb_line = scr;
    endfunction

    function automatic vppm_pkg::pix_t text_tr(input vppm_pkg::pix_t scr, input logic opaq,
                                               input vppm_pkg::pix_t s, input vppm_pkg::pix_t t,
                                               input logic ftext, input vppm_pkg::pix_t bl);
        if (opaq)
            text_tr = (s != '0) ? bl : (ftext ? t : '0);
        else if (ftext && t != '0)
            text_tr = (s != '0) ? bl : t;
        else
            text_tr = scr;
    endfunction

    function automatic vppm_pkg::pix_t bg_tr(input vppm_pkg::pix_t scr, input logic opaq,
                                             input vppm_pkg::pix_t s, input vppm_pkg::pix_t t,
                                             input logic fbg, input vppm_pkg::pix_t bl);
        if (opaq || (fbg && t != '0))
            bg_tr = (s != '0) ? bl : t;
        else
            bg_tr = scr;
    endfunction

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            priority_reg  <= '0;
            effect_reg    <= '0;
            plane_reg     <= '0;
            half_mask_reg <= '0;
            int_bit_reg   <= '0;
            int_add_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (vppm_pkg::cfg_index_t'(cfg.index))
                vppm_pkg::REG_PRIORITY:  priority_reg  <= cfg.data[vppm_pkg::PRI_W-1:0];
                vppm_pkg::REG_EFFECT:    effect_reg    <= cfg.data[vppm_pkg::EFF_W-1:0];
                vppm_pkg::REG_PLANE:     plane_reg     <= cfg.data[vppm_pkg::PLN_W-1:0];
                vppm_pkg::REG_HALF_MASK: half_mask_reg <= cfg.data;
                vppm_pkg::REG_INT_BIT:   int_bit_reg   <= cfg.data;
                vppm_pkg::REG_INT_ADD:   int_add_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    // handshake
    assign advance       = !s2_valid_reg || screen.ready;
    assign pixel.ready   = !s1_valid_reg || advance;
    assign take          = pixel.valid && pixel.ready;
    assign s1_valid_next = take || (s1_valid_reg && !advance);
    assign s2_valid_next = advance ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            g_reg <= pixel.graphics_pixel;
            s_reg <= pixel.sprite_graphics_pixel;
            p_reg <= pixel.plain_graphics_pixel;
            t_reg <= pixel.text_bg_pixel;
            f_reg <= pixel.text_bg_flags;
        end
        if (advance && s1_valid_reg)
            scr_reg <= scr_next;
    end

    // blend of the translucent layer into the text/BG dot
    assign w_mask    = s_reg & half_mask_reg;
    assign w_sum     = ((t_reg & int_bit_reg) != '0) ? w_mask + int_add_reg : w_mask;
    assign blend_sum = {1'b0, t_reg & half_mask_reg} + {1'b0, w_sum};
    assign blend     = blend_sum[vppm_pkg::PIX_W:1];

    always_comb
    begin
        logic [1:0]     gp;
        logic [1:0]     tp;
        logic [1:0]     bp;
        logic           gon;
        logic           tron;
        logic           pron;
        logic           ton;
        logic           bgon;
        logic           eff;
        logic           gblend;
        logic           opaq;
        logic           td;
        vppm_pkg::pix_t scr;

        gp     = priority_reg[1:0];
        tp     = priority_reg[3:2];
        bp     = priority_reg[5:4];
        gon    = plane_reg[vppm_pkg::PLN_GFX];
        tron   = plane_reg[vppm_pkg::PLN_TRANS];
        pron   = plane_reg[vppm_pkg::PLN_SPRI];
        ton    = plane_reg[vppm_pkg::PLN_TEXT];
        bgon   = plane_reg[vppm_pkg::PLN_BG];
        eff    = (effect_reg & vppm_pkg::EFF_HALF_MASK) == vppm_pkg::EFF_HALF_MODE;
        gblend = (effect_reg & vppm_pkg::EFF_GRAPH_BLEND) != '0;
        opaq   = 1'b1;
        td     = 1'b0;
        scr    = '0;

        // lowest level
        if (gp[1])
        begin
            if (gon)
            begin
                scr  = put(scr, g_reg, opaq);
                opaq = 1'b0;
            end
            if (tron)
            begin
                scr  = put(scr, p_reg, opaq);
                opaq = 1'b0;
            end
        end
        if (bp[1] && bgon)
        begin
            if (eff && gp != 2'd2 && tron)
            begin
                if (gp < tp)
                begin
                    scr  = bg_tr(scr, opaq, s_reg, t_reg, f_reg[vppm_pkg::FLG_BG], blend);
                    td   = 1'b1;
                    opaq = 1'b0;
                end
            end
            else
            begin
                scr  = tb_line(scr, opaq, td, f_reg[vppm_pkg::FLG_BG], t_reg);
                td   = 1'b1;
                opaq = 1'b0;
            end
        end
        if (tp[1] && ton)
        begin
            if (eff && gp != 2'd2 && tron)
                scr = text_tr(scr, opaq, s_reg, t_reg, f_reg[vppm_pkg::FLG_TEXT], blend);
            else
                scr = tb_line(scr, opaq, td, f_reg[vppm_pkg::FLG_TEXT], t_reg);
            opaq = 1'b0;
            td   = 1'b1;
        end

        // priority one
        if (gp == 2'd1 && gon)
        begin
            scr  = put(scr, g_reg, opaq);
            opaq = 1'b0;
        end
        if (bp == 2'd1 && bgon)
        begin
            if (eff && gp == 2'd0 && tron)
            begin
                if (gp < tp)
                begin
                    scr  = bg_tr(scr, opaq, s_reg, t_reg, f_reg[vppm_pkg::FLG_BG], blend);
                    td   = 1'b1;
                    opaq = 1'b0;
                end
            end
            else
            begin
                scr  = tb_line(scr, opaq, tp == 2'd2, f_reg[vppm_pkg::FLG_BG], t_reg);
                td   = 1'b1;
                opaq = 1'b0;
            end
        end
        if (tp == 2'd1 && eff && gp != 2'd0 && bp > gp && bgon && tron)
        begin
            scr  = bg_tr(scr, opaq, s_reg, t_reg, f_reg[vppm_pkg::FLG_BG], blend);
            td   = 1'b1;
            opaq = 1'b0;
            scr  = put(scr, p_reg, opaq);
        end
        else if (gp == 2'd1 && tron && gon && gblend)
        begin
            scr  = put(scr, p_reg, opaq);
            opaq = 1'b0;
        end
        if (tp == 2'd1 && ton)
        begin
            if (eff && gp == 2'd0 && tron)
                scr = text_tr(scr, opaq, s_reg, t_reg, f_reg[vppm_pkg::FLG_TEXT], blend);
            else
                scr = tb_line(scr, opaq, bp != 2'd0, f_reg[vppm_pkg::FLG_TEXT], t_reg);
            opaq = 1'b0;
            td   = 1'b1;
        end

        // top level
        if (gp == 2'd0 && gon)
        begin
            scr  = put(scr, g_reg, opaq);
            opaq = 1'b0;
        end
        if (bp == 2'd0 && bgon)
        begin
            scr  = tb_line(scr, opaq, tp != 2'd0, f_reg[vppm_pkg::FLG_BG], t_reg);
            td   = 1'b1;
            opaq = 1'b0;
        end
        if (tp == 2'd0 && eff && bp > gp && bgon && tron)
        begin
            scr  = bg_tr(scr, opaq, s_reg, t_reg, f_reg[vppm_pkg::FLG_BG], blend);
            td   = 1'b1;
            opaq = 1'b0;
            scr  = put(scr, p_reg, opaq);
        end
        else if (gp == 2'd0 && tron && gblend)
        begin
            scr  = put(scr, p_reg, opaq);
            opaq = 1'b0;
        end
        if (tp == 2'd0 && ton)
        begin
            scr  = tb_line(scr, opaq, 1'b1, f_reg[vppm_pkg::FLG_TEXT], t_reg);
            td   = 1'b1;
            opaq = 1'b0;
        end

        // special priority overlay or fill of empty dots
        if ((effect_reg & vppm_pkg::EFF_SPRI_MASK) == vppm_pkg::EFF_SPRI_MODE && pron)
        begin
            if (s_reg != '0)
                scr = s_reg;
        end
        else if ((effect_reg & vppm_pkg::EFF_HALF_MASK) == vppm_pkg::EFF_FILL_MODE && tron)
        begin
            if (s_reg != '0 && scr == '0)
                scr = w_mask >> 1;
        end

        if (opaq)
            scr = '0;

        scr_next = scr;
    end

    assign screen.valid        = s2_valid_reg;
    assign screen.screen_pixel = scr_reg;

`ifndef SYNTHESIS
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg)
        else $error("input stage dropped a stalled dot");

    a_move_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> s2_valid_reg)
        else $error("dot lost between stages");

    a_nothing_drawn: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance && plane_reg == '0 |=> screen.screen_pixel == '0)
        else $error("non-zero pixel with no plane present");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        take && s1_valid_reg |-> advance)
        else $error("input stage overwritten while stalled");
`endif

endmodule

// File: sim/video_plane_priority_mixer_tb.sv
// Testbench of the plane mixer: drives dots, predicts every screen pixel and checks each beat.
`timescale 1ns / 1ps

module video_plane_priority_mixer_tb;

    localparam int HOLD_CYCLES = 120;

    typedef struct packed {
        vppm_pkg::pix_t                  gfx;
        vppm_pkg::pix_t                  sprite;
        vppm_pkg::pix_t                  plain;
        vppm_pkg::pix_t                  text_bg;
        logic [vppm_pkg::FLAG_W-1:0]     flags;
    } dot_t;

    logic clk;
    logic rst_n;

    vppm_pix_if pix_bus ();
    vppm_scr_if scr_bus ();
    vppm_cfg_if cfg_bus ();

    video_plane_priority_mixer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_bus),
        .screen (scr_bus),
        .cfg    (cfg_bus)
    );

    logic [vppm_pkg::PRI_W-1:0] prio_r;
    logic [vppm_pkg::EFF_W-1:0] effect_r;
    logic [vppm_pkg::PLN_W-1:0] planes_r;
    vppm_pkg::pix_t             hmask_r;
    vppm_pkg::pix_t             ibit_r;
    vppm_pkg::pix_t             iadd_r;

    dot_t           pending_dots[$];
    vppm_pkg::pix_t expected_pixels[$];
    int             mismatch_count;
    int             src_idle_pct;
    int             snk_idle_pct;
    logic           hold_go;
    logic           sink_hold;

    function automatic vppm_pkg::pix_t blend_dot(vppm_pkg::pix_t base, vppm_pkg::pix_t ovl);
        vppm_pkg::pix_t w;
        logic [16:0]    sum;
        w = ovl & hmask_r;
        if ((base & ibit_r) != '0)
            w = w + iadd_r;
        sum = {1'b0, base & hmask_r} + {1'b0, w};
        return sum[16:1];
    endfunction

    function automatic vppm_pkg::pix_t put_plane(vppm_pkg::pix_t cur, vppm_pkg::pix_t v,
                                                 logic opaq);
        if (opaq || v != '0)
            return v;
        return cur;
    endfunction

    function automatic vppm_pkg::pix_t layer_text_bg(vppm_pkg::pix_t cur, logic opaq, logic td,
                                                     logic hit, vppm_pkg::pix_t t);
        if (opaq)
            return t;
        if (!td || hit)
            return put_plane(cur, t, 1'b0);
        return cur;
    endfunction

    function automatic vppm_pkg::pix_t half_text(vppm_pkg::pix_t cur, logic opaq,
                                                 vppm_pkg::pix_t s, vppm_pkg::pix_t t,
                                                 logic [vppm_pkg::FLAG_W-1:0] f);
        if (opaq) begin
            if (s != '0)
                return blend_dot(t, s);
            return f[vppm_pkg::FLG_TEXT] ? t : '0;
        end
        if (f[vppm_pkg::FLG_TEXT] && t != '0)
            return (s != '0) ? blend_dot(t, s) : t;
        return cur;
    endfunction

    function automatic vppm_pkg::pix_t half_bg(vppm_pkg::pix_t cur, logic opaq,
                                               vppm_pkg::pix_t s, vppm_pkg::pix_t t,
                                               logic [vppm_pkg::FLAG_W-1:0] f);
        if (opaq || (f[vppm_pkg::FLG_BG] && t != '0))
            return (s != '0) ? blend_dot(t, s) : t;
        return cur;
    endfunction

    function automatic vppm_pkg::pix_t predict_screen(dot_t d);
        logic [1:0]     gp;
        logic [1:0]     tp;
        logic [1:0]     bp;
        logic           gon;
        logic           tron;
        logic           pron;
        logic           ton;
        logic           bgon;
        logic           hmode;
        logic           gblend;
        logic           opaq;
        logic           td;
        vppm_pkg::pix_t scr;
        gp     = prio_r[1:0];
        tp     = prio_r[3:2];
        bp     = prio_r[5:4];
        gon    = planes_r[vppm_pkg::PLN_GFX];
        tron   = planes_r[vppm_pkg::PLN_TRANS];
        pron   = planes_r[vppm_pkg::PLN_SPRI];
        ton    = planes_r[vppm_pkg::PLN_TEXT];
        bgon   = planes_r[vppm_pkg::PLN_BG];
        hmode  = (effect_r & vppm_pkg::EFF_HALF_MASK) == vppm_pkg::EFF_HALF_MODE;
        gblend = (effect_r & vppm_pkg::EFF_GRAPH_BLEND) != '0;
        opaq   = 1'b1;
        td     = 1'b0;
        scr    = '0;

        if (prio_r[1])
        begin
            if (gon)
            begin
                scr  = put_plane(scr, d.gfx, opaq);
                opaq = 1'b0;
            end
            if (tron)
            begin
                scr  = put_plane(scr, d.plain, opaq);
                opaq = 1'b0;
            end
        end
        if (prio_r[5] && bgon)
        begin
            if (hmode && gp != 2'd2 && tron)
            begin
                if (gp < tp)
                begin
                    scr  = half_bg(scr, opaq, d.sprite, d.text_bg, d.flags);
                    td   = 1'b1;
                    opaq = 1'b0;
                end
            end
            else
            begin
                scr  = layer_text_bg(scr, opaq, td, d.flags[vppm_pkg::FLG_BG], d.text_bg);
                td   = 1'b1;
                opaq = 1'b0;
            end
        end
        if (prio_r[3] && ton)
        begin
            if (hmode && gp != 2'd2 && tron)
                scr = half_text(scr, opaq, d.sprite, d.text_bg, d.flags);
            else
                scr = layer_text_bg(scr, opaq, td, d.flags[vppm_pkg::FLG_TEXT], d.text_bg);
            opaq = 1'b0;
            td   = 1'b1;
        end

        if (gp == 2'd1 && gon)
        begin
            scr  = put_plane(scr, d.gfx, opaq);
            opaq = 1'b0;
        end
        if (bp == 2'd1 && bgon)
        begin
            if (hmode && gp == 2'd0 && tron)
            begin
                if (gp < tp)
                begin
                    scr  = half_bg(scr, opaq, d.sprite, d.text_bg, d.flags);
                    td   = 1'b1;
                    opaq = 1'b0;
                end
            end
            else
            begin
                scr  = layer_text_bg(scr, opaq, tp == 2'd2, d.flags[vppm_pkg::FLG_BG],
                                     d.text_bg);
                td   = 1'b1;
                opaq = 1'b0;
            end
        end
        if (tp == 2'd1 && hmode && gp != 2'd0 && bp > gp && bgon && tron)
        begin
            scr  = half_bg(scr, opaq, d.sprite, d.text_bg, d.flags);
            td   = 1'b1;
            opaq = 1'b0;
            scr  = put_plane(scr, d.plain, opaq);
        end
        else if (gp == 2'd1 && tron && gon && gblend)
        begin
            scr  = put_plane(scr, d.plain, opaq);
            opaq = 1'b0;
        end
        if (tp == 2'd1 && ton)
        begin
            if (hmode && gp == 2'd0 && tron)
                scr = half_text(scr, opaq, d.sprite, d.text_bg, d.flags);
            else
                scr = layer_text_bg(scr, opaq, bp >= 2'd1, d.flags[vppm_pkg::FLG_TEXT],
                                    d.text_bg);
            opaq = 1'b0;
            td   = 1'b1;
        end

        if (gp == 2'd0 && gon)
        begin
            scr  = put_plane(scr, d.gfx, opaq);
            opaq = 1'b0;
        end
        if (bp == 2'd0 && bgon)
        begin
            scr  = layer_text_bg(scr, opaq, tp >= 2'd1, d.flags[vppm_pkg::FLG_BG], d.text_bg);
            td   = 1'b1;
            opaq = 1'b0;
        end
        if (tp == 2'd0 && hmode && bp > gp && bgon && tron)
        begin
            scr  = half_bg(scr, opaq, d.sprite, d.text_bg, d.flags);
            td   = 1'b1;
            opaq = 1'b0;
            scr  = put_plane(scr, d.plain, opaq);
        end
        else if (gp == 2'd0 && tron && gblend)
        begin
            scr  = put_plane(scr, d.plain, opaq);
            opaq = 1'b0;
        end
        if (tp == 2'd0 && ton)
        begin
            scr  = layer_text_bg(scr, opaq, 1'b1, d.flags[vppm_pkg::FLG_TEXT], d.text_bg);
            opaq = 1'b0;
        end

        if ((effect_r & vppm_pkg::EFF_SPRI_MASK) == vppm_pkg::EFF_SPRI_MODE && pron)
        begin
            if (d.sprite != '0)
                scr = d.sprite;
        end
        else if ((effect_r & vppm_pkg::EFF_HALF_MASK) == vppm_pkg::EFF_FILL_MODE && tron)
        begin
            if (d.sprite != '0 && scr == '0)
                scr = (d.sprite & hmask_r) >> 1;
        end

        if (opaq)
            scr = '0;
        return scr;
    endfunction

    function automatic vppm_pkg::pix_t rand_pix();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_dot(vppm_pkg::pix_t g, vppm_pkg::pix_t s, vppm_pkg::pix_t p,
                             vppm_pkg::pix_t t, logic [vppm_pkg::FLAG_W-1:0] f);
        dot_t d;
        d.gfx     = g;
        d.sprite  = s;
        d.plain   = p;
        d.text_bg = t;
        d.flags   = f;
        pending_dots.push_back(d);
    endtask

    task automatic write_reg(vppm_pkg::cfg_index_t idx, logic [vppm_pkg::CFG_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            vppm_pkg::REG_PRIORITY:  prio_r   = val[vppm_pkg::PRI_W-1:0];
            vppm_pkg::REG_EFFECT:    effect_r = val[vppm_pkg::EFF_W-1:0];
            vppm_pkg::REG_PLANE:     planes_r = val[vppm_pkg::PLN_W-1:0];
            vppm_pkg::REG_HALF_MASK: hmask_r  = val;
            vppm_pkg::REG_INT_BIT:   ibit_r   = val;
            vppm_pkg::REG_INT_ADD:   iadd_r   = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(logic [vppm_pkg::PRI_W-1:0] pri,
                                logic [vppm_pkg::EFF_W-1:0] eff,
                                logic [vppm_pkg::PLN_W-1:0] pln, vppm_pkg::pix_t hm,
                                vppm_pkg::pix_t ib, vppm_pkg::pix_t ia);
        @(posedge clk);
        write_reg(vppm_pkg::REG_PRIORITY, vppm_pkg::CFG_W'(pri));
        write_reg(vppm_pkg::REG_EFFECT, vppm_pkg::CFG_W'(eff));
        write_reg(vppm_pkg::REG_PLANE, vppm_pkg::CFG_W'(pln));
        write_reg(vppm_pkg::REG_HALF_MASK, hm);
        write_reg(vppm_pkg::REG_INT_BIT, ib);
        write_reg(vppm_pkg::REG_INT_ADD, ia);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_phase();
        do
            @(posedge clk);
        while (pending_dots.size() != 0 || pix_bus.valid || expected_pixels.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("[video_plane_priority_mixer] ERROR");
        $finish;
    end

    // hold off the sink while the source keeps offering beats
    initial
    begin
        sink_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin : pixel_driver
        dot_t nxt;
        if (!rst_n)
        begin
            pix_bus.valid                 <= 1'b0;
            pix_bus.graphics_pixel        <= '0;
            pix_bus.sprite_graphics_pixel <= '0;
            pix_bus.plain_graphics_pixel  <= '0;
            pix_bus.text_bg_pixel         <= '0;
            pix_bus.text_bg_flags         <= '0;
        end
        else
        begin
            if (pix_bus.valid && pix_bus.ready)
            begin
                nxt.gfx     = pix_bus.graphics_pixel;
                nxt.sprite  = pix_bus.sprite_graphics_pixel;
                nxt.plain   = pix_bus.plain_graphics_pixel;
                nxt.text_bg = pix_bus.text_bg_pixel;
                nxt.flags   = pix_bus.text_bg_flags;
                expected_pixels.push_back(predict_screen(nxt));
            end
            if (!pix_bus.valid || pix_bus.ready)
            begin
                if (pending_dots.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    nxt = pending_dots.pop_front();
                    pix_bus.valid                 <= 1'b1;
                    pix_bus.graphics_pixel        <= nxt.gfx;
                    pix_bus.sprite_graphics_pixel <= nxt.sprite;
                    pix_bus.plain_graphics_pixel  <= nxt.plain;
                    pix_bus.text_bg_pixel         <= nxt.text_bg;
                    pix_bus.text_bg_flags         <= nxt.flags;
                end
                else
                    pix_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : screen_monitor
        vppm_pkg::pix_t want;
        if (!rst_n)
            scr_bus.ready <= 1'b0;
        else
        begin
            if (scr_bus.valid && scr_bus.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected screen beat: got %h", scr_bus.screen_pixel);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (scr_bus.screen_pixel !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("screen pixel mismatch: expected %h, got %h",
                                     want, scr_bus.screen_pixel);
                    end
                end
            end
            scr_bus.ready <= !sink_hold && ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    initial
    begin : stimulus
        int                         ph;
        int                         n;
        int                         cnt;
        logic [vppm_pkg::EFF_W-1:0] ev;
        logic [vppm_pkg::PLN_W-1:0] pv;
        vppm_pkg::pix_t             hv;
        vppm_pkg::pix_t             bv;
        vppm_pkg::pix_t             av;

        cfg_bus.valid  = 1'b0;
        cfg_bus.index  = vppm_pkg::REG_PRIORITY;
        cfg_bus.data   = '0;
        prio_r         = '0;
        effect_r       = '0;
        planes_r       = '0;
        hmask_r        = '0;
        ibit_r         = '0;
        iadd_r         = '0;
        mismatch_count = 0;
        src_idle_pct   = 26;
        snk_idle_pct   = 26;
        hold_go        = 1'b0;

        wait (rst_n === 1'b1);

        // no plane present after reset: every dot is blank
        queue_dot(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'b11);
        queue_dot(16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'b00);
        run_phase();

        // BG blend above graphics, intensity offset wrapping
        program_regs(8'h21, vppm_pkg::EFF_HALF_MODE, 5'h1F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_dot(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'b11);
        queue_dot(16'h0000, 16'hFFFF, 16'h0000, 16'h8001, 2'b10);
        queue_dot(16'h00FF, 16'h0000, 16'h0F0F, 16'hFFFF, 2'b00);
        queue_dot(16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'b00);
        run_phase();

        // opaque text blend at the bottom
        program_regs(8'h18, vppm_pkg::EFF_HALF_MODE, 5'h1F, 16'h7BDE, 16'h0001, 16'h0421);
        queue_dot(16'h1234, 16'h0000, 16'h5678, 16'h9ABC, 2'b00);
        queue_dot(16'h1234, 16'h0000, 16'h5678, 16'h9ABC, 2'b01);
        queue_dot(16'h0000, 16'h4321, 16'h0000, 16'h8765, 2'b10);
        queue_dot(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 2'b11);
        run_phase();

        // fill of empty dots
        program_regs(8'h3F, vppm_pkg::EFF_FILL_MODE, 5'h03, 16'hFFFF, 16'h0000, 16'h0000);
        queue_dot(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 2'b00);
        queue_dot(16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'b11);
        queue_dot(16'h0000, 16'h0003, 16'h2222, 16'h0000, 2'b01);
        run_phase();

        // special priority overlay
        program_regs(8'h00, vppm_pkg::EFF_SPRI_MODE, 5'h1F, 16'h0000, 16'h0000, 16'h0000);
        queue_dot(16'h1111, 16'h0000, 16'h2222, 16'h3333, 2'b11);
        queue_dot(16'h1111, 16'hAAAA, 16'h2222, 16'h3333, 2'b01);
        queue_dot(16'h0000, 16'h5555, 16'h0000, 16'h0000, 2'b00);
        run_phase();

        program_regs(8'hFF, 8'hFF, 5'h1F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_dot(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'b11);
        queue_dot(16'h0000, 16'h8000, 16'h0000, 16'h0001, 2'b10);
        queue_dot(16'h0001, 16'h0000, 16'h8000, 16'h0000, 2'b01);
        run_phase();

        // translucent graphics over normal graphics
        program_regs(8'h01, vppm_pkg::EFF_GRAPH_BLEND, 5'h1F, 16'h7BDE, 16'h0000, 16'h0000);
        queue_dot(16'h1111, 16'h0000, 16'h0000, 16'h3333, 2'b00);
        queue_dot(16'h1111, 16'h0000, 16'h2222, 16'h3333, 2'b11);
        queue_dot(16'h0000, 16'h0000, 16'h2222, 16'h0000, 2'b10);
        run_phase();

        for (ph = 0; ph < 18; ph++)
        begin
            case (ph)
                0: program_regs(8'h00, 8'h00, 5'h00, 16'h0000, 16'h0000, 16'h0000);
                1: program_regs(8'hFF, 8'hFF, 5'h1F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       ev = vppm_pkg::EFF_HALF_MODE | (8'($urandom) & 8'hA2);
                        1:       ev = vppm_pkg::EFF_FILL_MODE | (8'($urandom) & 8'hA2);
                        2:       ev = vppm_pkg::EFF_SPRI_MODE | (8'($urandom) & 8'hA3);
                        3:       ev = 8'($urandom) | vppm_pkg::EFF_GRAPH_BLEND;
                        default: ev = 8'($urandom);
                    endcase
                    pv = $urandom_range(0, 1) ? 5'h1F : 5'($urandom);
                    case ($urandom_range(0, 2))
                        0:       hv = 16'hFFFF;
                        1:       hv = 16'h7BDE;
                        default: hv = 16'($urandom);
                    endcase
                    bv = $urandom_range(0, 1) ? 16'h0001 : 16'($urandom);
                    av = 16'($urandom);
                    program_regs(8'($urandom), ev, pv, hv, bv, av);
                end
            endcase
            src_idle_pct = (ph == 7) ? 0 : 26;
            snk_idle_pct = (ph == 7) ? 0 : 26;
            cnt = (ph == 7) ? 100 : 32;
            for (n = 0; n < cnt; n++)
                queue_dot(rand_pix(), rand_pix(), rand_pix(), rand_pix(),
                          2'($urandom_range(0, 3)));
            if (ph == 4)
                hold_go = 1'b1;
            run_phase();
        end

        if (mismatch_count == 0)
            $display("[video_plane_priority_mixer] OK");
        else
            $display("[video_plane_priority_mixer] ERROR");
        $finish;
    end

endmodule
